// ----- hw/rtl/hafd_pkg.sv -----
package hafd_pkg;

    localparam int FRAME_BYTES_DEF    = 19;
    localparam int MAX_DATA_BYTES_DEF = 8;

    localparam logic [7:0] STOP_CHAR   = 8'd120;
    localparam logic [7:0] ALPHA_FIRST = 8'd65;
    localparam logic [7:0] ALPHA_BASE  = 8'd55;
    localparam logic [7:0] DIGIT_BASE  = 8'd48;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] msg_id;
        logic [7:0] data_byte;
        logic [2:0] byte_index;
        logic [3:0] data_length;
        logic       last;
    } result_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= ALPHA_FIRST)
        begin
            v = c - ALPHA_BASE;
        end
        else
        begin
            v = c - DIGIT_BASE;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/hex_ascii_frame_decoder_top.sv -----
// Decodes fixed frames of FRAME_BYTES ASCII bytes: a start mark, two hex digits of a message ID
// and then pairs of hex digits, each pair one data byte, until an 'x' opens a pair or the frame
// ends. Every completed data byte leaves as a transaction with its index, and after the last
// frame byte a frame-end transaction carries the ID and the data length. One byte is taken in
// every cycle while in_ready is high; a final frame byte that also completes a data byte yields
// two transactions, which both enter the four-entry result queue at once, and in_ready is high
// while at least two queue entries are free.
module hex_ascii_frame_decoder_top #(
    parameter int FRAME_BYTES    = hafd_pkg::FRAME_BYTES_DEF,
    parameter int MAX_DATA_BYTES = hafd_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] msg_id,
    output logic [7:0] data_byte,
    output logic [2:0] byte_index,
    output logic [3:0] data_length,
    output logic       last
);

    localparam int PW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(MAX_DATA_BYTES + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_DATA_BYTES);
    localparam logic [PW-1:0] POS_HI   = PW'(1);
    localparam logic [PW-1:0] POS_LO   = PW'(2);
    localparam logic [PW-1:0] POS_DATA = PW'(3);

    logic [PW-1:0] pos_reg, pos_next;
    logic [3:0]    high_reg, high_next;
    logic [7:0]    id_reg, id_next;
    logic [CW-1:0] count_reg, count_next;
    logic          stopped_reg, stopped_next;

    hafd_pkg::result_t fifo_mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;

    logic              accept;
    logic              pop;
    logic              is_last;
    logic              has_data;
    logic [7:0]        dval;
    logic [7:0]        dbyte;
    logic [31:0]       idx_wide;
    logic [31:0]       len_wide;
    logic [1:0]        push_n;
    hafd_pkg::result_t data_res;
    hafd_pkg::result_t end_res;
    hafd_pkg::result_t slot0;

    assign in_ready  = (fill_reg <= 3'd2);
    assign out_valid = (fill_reg != 3'd0);
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign dval     = hafd_pkg::digit_value(rx_byte);
    assign dbyte    = {high_reg, 4'b0000} + dval;
    assign is_last  = (pos_reg == LAST_POS);
    assign idx_wide = 32'(count_reg);

    always_comb
    begin
        pos_next     = is_last ? '0 : pos_reg + PW'(1);
        high_next    = high_reg;
        id_next      = id_reg;
        count_next   = count_reg;
        stopped_next = stopped_reg;
        has_data     = 1'b0;
        if (pos_reg == POS_HI)
        begin
            high_next = dval[3:0];
        end
        else if (pos_reg == POS_LO)
        begin
            id_next = {high_reg, 4'b0000} + dval;
        end
        else if (pos_reg >= POS_DATA && !stopped_reg)
        begin
            if (pos_reg[0])
            begin
                if (rx_byte == hafd_pkg::STOP_CHAR)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    high_next = dval[3:0];
                end
            end
            else if (count_reg < MAX_CNT)
            begin
                has_data   = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
        len_wide = 32'(count_next);
        if (is_last)
        begin
            high_next    = '0;
            count_next   = '0;
            stopped_next = 1'b0;
        end
    end

    always_comb
    begin
        data_res.kind        = hafd_pkg::KIND_DATA;
        data_res.msg_id      = id_reg;
        data_res.data_byte   = dbyte;
        data_res.byte_index  = idx_wide[2:0];
        data_res.data_length = 4'd0;
        data_res.last        = 1'b0;
        end_res.kind         = hafd_pkg::KIND_END;
        end_res.msg_id       = id_next;
        end_res.data_byte    = 8'd0;
        end_res.byte_index   = 3'd0;
        end_res.data_length  = len_wide[3:0];
        end_res.last         = 1'b1;
        slot0                = has_data ? data_res : end_res;
        push_n               = accept ? ({1'b0, has_data} + {1'b0, is_last}) : 2'd0;
        wr_ptr_next          = wr_ptr_reg + push_n;
        rd_ptr_next          = rd_ptr_reg + {1'b0, pop};
        fill_next            = fill_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            high_reg    <= '0;
            id_reg      <= '0;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg     <= pos_next;
                high_reg    <= high_next;
                id_reg      <= id_next;
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + 2'd1] <= end_res;
        end
    end

    assign kind        = fifo_mem[rd_ptr_reg].kind;
    assign msg_id      = fifo_mem[rd_ptr_reg].msg_id;
    assign data_byte   = fifo_mem[rd_ptr_reg].data_byte;
    assign byte_index  = fifo_mem[rd_ptr_reg].byte_index;
    assign data_length = fifo_mem[rd_ptr_reg].data_length;
    assign last        = fifo_mem[rd_ptr_reg].last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'd4)
        else $error("Result queue overflow.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("Data count exceeds the maximum.");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_last) |=> (pos_reg == '0 && count_reg == '0 && !stopped_reg))
        else $error("Frame state not cleared at frame end.");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == kind))
        else $error("Last flag disagrees with result kind.");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (fill_reg + {1'b0, push_n} <= 3'd4))
        else $error("Accepted byte does not fit the result queue.");
`endif

endmodule

// ----- sim/hex_ascii_frame_decoder_top_tb.sv -----
module hex_ascii_frame_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN     = hafd_pkg::FRAME_BYTES_DEF;
    localparam int DATA_MAX      = hafd_pkg::MAX_DATA_BYTES_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 40;
    localparam logic [7:0] START_MARK = 8'h3A;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'h00;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic       kind;
    logic [7:0] msg_id;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic [3:0] data_length;
    logic       last;

    hafd_pkg::result_t pending_results[$];
    int         mismatches  = 0;
    int         cycles      = 0;
    bit         quiet       = 1'b0;

    int         pos_in_frame = 0;
    logic [3:0] hi_digit     = 4'h0;
    logic [7:0] frame_id     = 8'h00;
    int         data_seen    = 0;
    bit         stop_seen    = 1'b0;

    hex_ascii_frame_decoder_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .msg_id      (msg_id),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .data_length (data_length),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("hex_ascii_frame_decoder_top_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    task automatic decode_rx_byte(input logic [7:0] c);
        logic [7:0]        v;
        logic [7:0]        b;
        hafd_pkg::result_t r;
        v = (c >= hafd_pkg::ALPHA_FIRST) ? c - hafd_pkg::ALPHA_BASE : c - hafd_pkg::DIGIT_BASE;
        if (pos_in_frame == 1)
        begin
            hi_digit = v[3:0];
        end
        else if (pos_in_frame == 2)
        begin
            frame_id = {hi_digit, 4'h0} + v;
        end
        else if (pos_in_frame >= 3 && !stop_seen)
        begin
            if (((pos_in_frame - 3) % 2) == 0)
            begin
                if (c == hafd_pkg::STOP_CHAR)
                begin
                    stop_seen = 1'b1;
                end
                else
                begin
                    hi_digit = v[3:0];
                end
            end
            else if (data_seen < DATA_MAX)
            begin
                b = {hi_digit, 4'h0} + v;
                r.kind        = hafd_pkg::KIND_DATA;
                r.msg_id      = frame_id;
                r.data_byte   = b;
                r.byte_index  = 3'(data_seen);
                r.data_length = 4'h0;
                r.last        = 1'b0;
                pending_results.push_back(r);
                data_seen++;
            end
        end
        if (pos_in_frame + 1 >= FRAME_LEN)
        begin
            r.kind        = hafd_pkg::KIND_END;
            r.msg_id      = frame_id;
            r.data_byte   = 8'h00;
            r.byte_index  = 3'h0;
            r.data_length = 4'(data_seen);
            r.last        = 1'b1;
            pending_results.push_back(r);
            pos_in_frame = 0;
            hi_digit     = 4'h0;
            data_seen    = 0;
            stop_seen    = 1'b0;
        end
        else
        begin
            pos_in_frame++;
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        hafd_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected transaction, expected none, actual kind %0d id %0d",
                             $time, kind, msg_id);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, kind);
                check_field("msg_id", want.msg_id, msg_id);
                check_field("data_byte", want.data_byte, data_byte);
                check_field("byte_index", want.byte_index, byte_index);
                check_field("data_length", want.data_length, data_length);
                check_field("last", want.last, last);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        decode_rx_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic lower;
        lower = ($urandom_range(0, 7) == 0);
        if (n < 4'd10)
        begin
            return 8'd48 + 8'(n);
        end
        return (lower ? 8'd87 : 8'd55) + 8'(n);
    endfunction

    task automatic send_random_frame(input bit noisy);
        logic [7:0] frame_bytes[FRAME_LEN];
        int         pairs;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            frame_bytes[i] = ($urandom_range(0, 7) == 0) ? hafd_pkg::STOP_CHAR : 8'($urandom);
        end
        if (!noisy)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                frame_bytes[0] = START_MARK;
            end
            frame_bytes[1] = hex_char(4'($urandom));
            frame_bytes[2] = hex_char(4'($urandom));
            pairs = $urandom_range(0, DATA_MAX);
            for (int k = 0; k < pairs && 4 + 2 * k < FRAME_LEN; k++)
            begin
                frame_bytes[3 + 2 * k] = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                                       : hex_char(4'($urandom));
                if ($urandom_range(0, 19) == 0)
                begin
                    frame_bytes[4 + 2 * k] = hafd_pkg::STOP_CHAR;
                end
                else
                begin
                    frame_bytes[4 + 2 * k] = ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                                                       : hex_char(4'($urandom));
                end
                if (frame_bytes[3 + 2 * k] == hafd_pkg::STOP_CHAR)
                begin
                    frame_bytes[3 + 2 * k] = hex_char(4'($urandom));
                end
            end
            if (3 + 2 * pairs < FRAME_LEN)
            begin
                frame_bytes[3 + 2 * pairs] = hafd_pkg::STOP_CHAR;
            end
        end
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Eight pairs fill the frame, so its final byte completes a data byte and ends the frame.
    task automatic test_full_frame();
        send_text(":0000FF9AF00FA91G");
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_stop_mark();
        send_byte(8'hFF);
        send_text("FF1x7ex12345678901");
    endtask

    task automatic test_wellformed_frames(input int count);
        for (int f = 0; f < count; f++)
        begin
            quiet = (f >= count / 3 && f < count / 2);
            send_random_frame(1'b0);
        end
        quiet = 1'b0;
    endtask

    task automatic test_noise_frames(input int count);
        for (int f = 0; f < count; f++)
        begin
            send_random_frame(1'b1);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_full_frame();
        test_stop_mark();
        test_wellformed_frames(80);
        test_noise_frames(15);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("hex_ascii_frame_decoder_top_tb: PASS");
        end
        else
        begin
            $display("hex_ascii_frame_decoder_top_tb: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/hafd_pkg.sv
hw/rtl/hex_ascii_frame_decoder_top.sv
sim/hex_ascii_frame_decoder_top_tb.sv
